@@ rtl/core/accumulator_machine_execute_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator machine execute unit
// Clocked property checks with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// check a property on every rising edge outside reset
`define AME_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising edge, reset included
`define AME_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ame_pkg.sv @@
// ----------------------------------------------------------------------------
// ame_pkg
// Types and constants of the accumulator machine execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ame_pkg;

  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(DATA_W);
  localparam int OP_W       = 5;
  localparam int PC_FIELD_W = 11;
  localparam int STATUS_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_MUL = 5'd2,
    OP_DIV = 5'd3,
    OP_LDA = 5'd4,
    OP_LDK = 5'd5,
    OP_STA = 5'd6,
    OP_INP = 5'd7,
    OP_OUT = 5'd8,
    OP_HLT = 5'd9,
    OP_JMP = 5'd10,
    OP_JEZ = 5'd11,
    OP_JNE = 5'd12,
    OP_JLZ = 5'd13,
    OP_JLE = 5'd14,
    OP_JGZ = 5'd15,
    OP_JGE = 5'd16
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_HALT       = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_DIV_ZERO   = 3'd3,
    ST_IO         = 3'd4,
    ST_UNKNOWN    = 3'd5,
    ST_END        = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/accumulator_machine_execute_unit.sv @@
// ----------------------------------------------------------------------------
// Accumulator machine execute unit
// Each input transaction is one instruction (opcode, operand) executed at the
// current program counter; each one returns exactly one result transaction
// with the next pc, the accumulator, the halted flag and the stop status.
// The unit takes one instruction at a time: in_ready is high only while the
// sequencer is idle. An accepted instruction passes through the fetch,
// execute and done states; MUL and DIV add 32 shift-and-add or restoring
// subtract steps between execute and done, through the one shared 33-bit
// adder (DIV adds one sign fix step). A finished result waits in the output
// register while the next instruction is accepted; a result still waiting
// there when the next one finishes holds the sequencer until out_ready. Data
// words sit in a small memory with one valid bit per word, so reset needs no
// clearing pass. The program length register is written through the cfg
// port, which is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accumulator_machine_execute_unit #(
  parameter int DATA_WORDS  = 8,
  parameter int MAX_PROGRAM = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ame_pkg::PC_FIELD_W-1:0]       cfg_program_length,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ame_pkg::OP_W-1:0]             in_opcode,
  input  logic [ame_pkg::DATA_W-1:0]           in_operand,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ame_pkg::PC_FIELD_W-1:0]       out_next_pc,
  output logic signed [ame_pkg::DATA_W-1:0]    out_accumulator,
  output logic                                 out_halted,
  output logic [ame_pkg::STATUS_W-1:0]         out_status
);

  localparam int DW    = ame_pkg::DATA_W;
  localparam int CW    = ame_pkg::CNT_W;
  localparam int PCF_W = ame_pkg::PC_FIELD_W;
  localparam int PC_W  = $clog2(MAX_PROGRAM + 1);
  localparam int CMP_W = (PC_W > PCF_W) ? PC_W : PCF_W;
  localparam int IDX_W = $clog2(DATA_WORDS);

  localparam logic [PC_W-1:0]  PC_MAX   = PC_W'(MAX_PROGRAM);
  localparam logic [DW-1:0]    PC_MAX_W = DW'(MAX_PROGRAM);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(DATA_WORDS - 1);
  localparam logic [CW-1:0]    CNT_LAST = CW'(DW - 1);

  ame_pkg::state_t  state_r, state_nxt;
  ame_pkg::op_t     op_r, op_nxt;
  ame_pkg::status_t cause_r, cause_nxt;
  ame_pkg::status_t fcause_r, fcause_nxt;

  logic [DW-1:0]    arg_r, arg_nxt;
  logic [DW-1:0]    acc_r, acc_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic             stopped_r, stopped_nxt;
  logic [PCF_W-1:0] plen_r;
  logic [DW-1:0]    res_r, res_nxt;
  logic [PC_W-1:0]  npc_r, npc_nxt;
  logic             commit_r, commit_nxt;
  logic             sta_r, sta_nxt;
  logic             halt_r, halt_nxt;
  logic [DW-1:0]    a_r, a_nxt;
  logic [DW-1:0]    p_r, p_nxt;
  logic [DW-1:0]    q_r, q_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PCF_W-1:0] out_pc_r, out_pc_nxt;
  logic [DW-1:0]    out_acc_r, out_acc_nxt;
  logic             out_halted_r, out_halted_nxt;
  ame_pkg::status_t out_status_r, out_status_nxt;

  logic [DW-1:0]         mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld_r;
  logic [DW-1:0]         rd_r;
  logic                  rd_vld_r;
  logic                  mem_we;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] sta_idx;
  logic [DW-1:0]    val;
  logic             end_cur;
  logic             end_npc;
  logic [PC_W:0]    pc_inc;
  logic [DW-1:0]    tgt;
  logic             uses_idx;
  logic             bad_idx;
  logic             jump;
  logic             done_go;

  logic [DW:0]      alu_x;
  logic [DW:0]      alu_y;
  logic             alu_sub;
  logic [DW:0]      alu_sum;
  logic [DW-1:0]    div_shift;

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == ame_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_accumulator = $signed(out_acc_r);
  assign out_halted      = out_halted_r;
  assign out_status      = out_status_r;

  assign rd_idx    = arg_r[IDX_W-1:0];
  assign sta_idx   = arg_r[IDX_W-1:0] & IDX_MASK;
  assign val       = (rd_idx == '0) ? acc_r : (rd_vld_r ? rd_r : '0);
  assign end_cur   = (CMP_W'(pc_r) >= CMP_W'(plen_r)) || (pc_r == PC_MAX);
  assign end_npc   = (CMP_W'(npc_r) >= CMP_W'(plen_r)) || (npc_r == PC_MAX);
  assign pc_inc    = {1'b0, pc_r} + (PC_W + 1)'(1);
  assign tgt       = arg_r - DW'(1);
  assign uses_idx  = op_r inside {ame_pkg::OP_ADD, ame_pkg::OP_SUB, ame_pkg::OP_MUL,
                                  ame_pkg::OP_DIV, ame_pkg::OP_LDA, ame_pkg::OP_STA};
  assign bad_idx   = uses_idx && (arg_r >= DW'(DATA_WORDS));
  assign done_go   = !out_valid_r || out_ready;
  assign div_shift = {p_r[DW-2:0], q_r[DW-1]};

  // shared adder
  assign alu_sum = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    arg_nxt        = arg_r;
    acc_nxt        = acc_r;
    pc_nxt         = pc_r;
    stopped_nxt    = stopped_r;
    cause_nxt      = cause_r;
    fcause_nxt     = fcause_r;
    res_nxt        = res_r;
    npc_nxt        = npc_r;
    commit_nxt     = commit_r;
    sta_nxt        = sta_r;
    halt_nxt       = halt_r;
    a_nxt          = a_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pc_nxt     = out_pc_r;
    out_acc_nxt    = out_acc_r;
    out_halted_nxt = out_halted_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    alu_x          = '0;
    alu_y          = '0;
    alu_sub        = 1'b0;
    jump           = 1'b0;

    case (state_r)
      ame_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = ame_pkg::op_t'(in_opcode);
          arg_nxt   = in_operand;
          state_nxt = ame_pkg::S_FETCH;
        end
      end

      ame_pkg::S_FETCH: begin
        state_nxt = ame_pkg::S_EXEC;
      end

      ame_pkg::S_EXEC: begin
        commit_nxt = 1'b0;
        sta_nxt    = 1'b0;
        halt_nxt   = 1'b0;
        res_nxt    = acc_r;
        fcause_nxt = ame_pkg::ST_OK;
        state_nxt  = ame_pkg::S_DONE;
        if (stopped_r) begin
          fcause_nxt = cause_r;
        end else if (end_cur) begin
          fcause_nxt = ame_pkg::ST_END;
        end else if (bad_idx) begin
          fcause_nxt = ame_pkg::ST_BAD_INDEX;
        end else begin
          commit_nxt = 1'b1;
          case (op_r)
            ame_pkg::OP_ADD: begin
              alu_x   = {1'b0, acc_r};
              alu_y   = {1'b0, val};
              res_nxt = alu_sum[DW-1:0];
            end
            ame_pkg::OP_SUB: begin
              alu_x   = {1'b0, acc_r};
              alu_y   = {1'b0, val};
              alu_sub = 1'b1;
              res_nxt = alu_sum[DW-1:0];
            end
            ame_pkg::OP_MUL: begin
              a_nxt     = acc_r;
              q_nxt     = val;
              p_nxt     = '0;
              cnt_nxt   = '0;
              state_nxt = ame_pkg::S_MUL;
            end
            ame_pkg::OP_DIV: begin
              if (val == '0) begin
                commit_nxt = 1'b0;
                fcause_nxt = ame_pkg::ST_DIV_ZERO;
              end else begin
                a_nxt     = val[DW-1] ? (DW'(0) - val) : val;
                q_nxt     = acc_r[DW-1] ? (DW'(0) - acc_r) : acc_r;
                p_nxt     = '0;
                cnt_nxt   = '0;
                neg_nxt   = acc_r[DW-1] ^ val[DW-1];
                state_nxt = ame_pkg::S_DIV;
              end
            end
            ame_pkg::OP_LDA: res_nxt = val;
            ame_pkg::OP_LDK: res_nxt = arg_r;
            ame_pkg::OP_STA: sta_nxt = 1'b1;
            ame_pkg::OP_INP, ame_pkg::OP_OUT: begin
              commit_nxt = 1'b0;
              fcause_nxt = ame_pkg::ST_IO;
            end
            ame_pkg::OP_HLT: halt_nxt = 1'b1;
            ame_pkg::OP_JMP: jump = 1'b1;
            ame_pkg::OP_JEZ: jump = (acc_r == '0);
            ame_pkg::OP_JNE: jump = (acc_r != '0);
            ame_pkg::OP_JLZ: jump = acc_r[DW-1];
            ame_pkg::OP_JLE: jump = (acc_r == '0) || acc_r[DW-1];
            ame_pkg::OP_JGZ: jump = (acc_r != '0) && !acc_r[DW-1];
            ame_pkg::OP_JGE: jump = !acc_r[DW-1];
            default: begin
              commit_nxt = 1'b0;
              fcause_nxt = ame_pkg::ST_UNKNOWN;
            end
          endcase
        end
        if (jump) begin
          npc_nxt = (tgt > PC_MAX_W) ? PC_MAX : tgt[PC_W-1:0];
        end else begin
          npc_nxt = (pc_inc > (PC_W + 1)'(MAX_PROGRAM)) ? PC_MAX : pc_inc[PC_W-1:0];
        end
      end

      ame_pkg::S_MUL: begin
        alu_x   = {1'b0, p_r};
        alu_y   = {1'b0, q_r[0] ? a_r : '0};
        p_nxt   = alu_sum[DW-1:0];
        a_nxt   = {a_r[DW-2:0], 1'b0};
        q_nxt   = {1'b0, q_r[DW-1:1]};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          res_nxt   = alu_sum[DW-1:0];
          state_nxt = ame_pkg::S_DONE;
        end
      end

      ame_pkg::S_DIV: begin
        alu_x   = {1'b0, div_shift};
        alu_y   = {1'b0, a_r};
        alu_sub = 1'b1;
        if (!alu_sum[DW]) begin
          p_nxt = alu_sum[DW-1:0];
          q_nxt = {q_r[DW-2:0], 1'b1};
        end else begin
          p_nxt = div_shift;
          q_nxt = {q_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ame_pkg::S_FIX;
        end
      end

      ame_pkg::S_FIX: begin
        alu_y     = {1'b0, q_r};
        alu_sub   = 1'b1;
        res_nxt   = neg_r ? alu_sum[DW-1:0] : q_r;
        state_nxt = ame_pkg::S_DONE;
      end

      ame_pkg::S_DONE: begin
        if (done_go) begin
          if (!stopped_r) begin
            if (commit_r) begin
              pc_nxt = npc_r;
              if (sta_r) begin
                mem_we = 1'b1;
              end else begin
                acc_nxt = res_r;
              end
              if (halt_r) begin
                stopped_nxt = 1'b1;
                cause_nxt   = ame_pkg::ST_HALT;
              end else if (end_npc) begin
                stopped_nxt = 1'b1;
                cause_nxt   = ame_pkg::ST_END;
              end
            end else begin
              stopped_nxt = 1'b1;
              cause_nxt   = fcause_r;
            end
          end
          out_valid_nxt  = 1'b1;
          out_pc_nxt     = PCF_W'(pc_nxt);
          out_acc_nxt    = acc_nxt;
          out_halted_nxt = stopped_nxt;
          out_status_nxt = cause_nxt;
          state_nxt      = ame_pkg::S_IDLE;
        end
      end

      default: state_nxt = ame_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ame_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      pc_r        <= '0;
      stopped_r   <= 1'b0;
      cause_r     <= ame_pkg::ST_OK;
      plen_r      <= '0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      pc_r        <= pc_nxt;
      stopped_r   <= stopped_nxt;
      cause_r     <= cause_nxt;
      if (cfg_valid) begin
        plen_r <= cfg_program_length;
      end
      if (mem_we) begin
        vld_r[sta_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    arg_r        <= arg_nxt;
    fcause_r     <= fcause_nxt;
    res_r        <= res_nxt;
    npc_r        <= npc_nxt;
    commit_r     <= commit_nxt;
    sta_r        <= sta_nxt;
    halt_r       <= halt_nxt;
    a_r          <= a_nxt;
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    out_pc_r     <= out_pc_nxt;
    out_acc_r    <= out_acc_nxt;
    out_halted_r <= out_halted_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sta_idx] <= acc_r;
    end
    rd_r     <= mem[rd_idx];
    rd_vld_r <= vld_r[rd_idx];
  end

`include "accumulator_machine_execute_unit_assert.svh"

  `AME_ASSERT(a_stop_sticky, stopped_r |=> stopped_r, "stopped flag cleared")
  `AME_ASSERT(a_pc_bound, pc_r <= PC_MAX, "pc above program limit")
  `AME_ASSERT(a_out_status,
              out_valid_r |-> (out_halted_r == (out_status_r != ame_pkg::ST_OK)),
              "halted and status disagree")
  `AME_ASSERT(a_accept_fetch,
              (in_valid && in_ready) |=> (state_r == ame_pkg::S_FETCH),
              "accepted transaction not fetched")

endmodule
